// File: hw/rtl/kvpt_pkg.sv
package kvpt_pkg;

	localparam logic [7:0] SPACE_BYTE = 8'd32;

	// result kinds (m_tuser)
	localparam logic [1:0] K_KEY   = 2'd0;
	localparam logic [1:0] K_VALUE = 2'd1;
	localparam logic [1:0] K_END   = 2'd2;
	localparam logic [1:0] K_ERR   = 2'd3;

	// error codes carried in the payload of an error result
	localparam logic [7:0] E_EMPTY_KEY  = 8'd0;
	localparam logic [7:0] E_NO_DELIM   = 8'd1;
	localparam logic [7:0] E_KEY_LONG   = 8'd2;

	// configuration register indexes
	localparam logic [2:0] R_ITEM_DELIM   = 3'd0;
	localparam logic [2:0] R_KV_DELIM     = 3'd1;
	localparam logic [2:0] R_ESCAPE_BYTE  = 3'd2;
	localparam logic [2:0] R_QUOTE_ENABLE = 3'd3;
	localparam logic [2:0] R_QUOTE_BYTE   = 3'd4;

	typedef enum logic [5:0] {
		PH_KEY       = 6'b000001,
		PH_EXPECT_KV = 6'b000010,
		PH_AFTER_KV  = 6'b000100,
		PH_TRIM      = 6'b001000,
		PH_VALUE     = 6'b010000,
		PH_ERROR     = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_KEY  = 3'b010,
		SQ_TAIL = 3'b100
	} seq_t;

endpackage

// File: hw/rtl/key_value_pair_tokenizer_unit.sv
// Channel  | Signals                                  | Moves
// ---------+------------------------------------------+-------------------------------
// s_       | s_tvalid s_tready s_tdata s_tlast        | text byte, end-of-text flag
// m_       | m_tvalid m_tready m_tdata m_tuser m_tlast | result: payload, kind, run last
// cfg_     | cfg_valid cfg_ready cfg_index cfg_data   | register write request
//
// An input byte is held in one register and decoded while the sequencer is idle; each result
// then passes through the output register, and a byte that gives no result is released at
// decode. A key run reads the key memory one byte a cycle while the m_ side is not stalled.
// Reset clears phase, key length, escape and quote flags and restores the register defaults;
// the key memory is not cleared. A stalled m_ side holds the sequencer, and the next byte
// is taken only when the current one has given all its results to the output register.
module key_value_pair_tokenizer_unit #(
	parameter int MAX_KEY_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast,   // run_last
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int LW = $clog2(MAX_KEY_LEN + 1);
	localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

	// configuration
	logic [7:0] item_delim_q, kv_delim_q, escape_byte_q, quote_byte_q;
	logic       quote_enable_q;

	// parser state
	kvpt_pkg::phase_t phase_q, nx_phase;
	logic [LW-1:0]    key_len_q, nx_len;
	logic             esc_q, nx_esc;
	logic             quote_q, nx_quote;

	// held input item
	logic       have_q;
	logic [7:0] byte_q;
	logic       eot_q;

	// sequencer
	kvpt_pkg::seq_t seq_q;
	logic [AW-1:0]  cnt_q, cnt_d;
	logic [LW-1:0]  burst_len_q;
	logic           t0v_q, t1v_q;
	logic [1:0]     t0_kind_q;
	logic [7:0]     t0_pay_q;

	// key memory
	logic [7:0]    key_mem [MAX_KEY_LEN];
	logic [7:0]    rd_data_q;
	logic          wr_en;

	// decode results
	logic       burst, t0_v, t1_v;
	logic [1:0] t0_kind;
	logic [7:0] t0_pay;

	// output register
	logic       m_tvalid_q, m_tlast_q;
	logic [7:0] m_tdata_q;
	logic [1:0] m_tuser_q;
	logic       out_free;
	logic       decode;
	logic       key_last;

	assign cfg_ready = 1'b1;
	assign s_tready  = !have_q;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign decode   = have_q && (seq_q == kvpt_pkg::SQ_IDLE);
	// the key length may restart at decode, so the run uses its own copy
	assign key_last = (LW'(cnt_q) == burst_len_q - LW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_delim_q   <= 8'd44;
			kv_delim_q     <= 8'd58;
			escape_byte_q  <= 8'd92;
			quote_enable_q <= 1'b0;
			quote_byte_q   <= 8'd34;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kvpt_pkg::R_ITEM_DELIM:   item_delim_q   <= cfg_data;
				kvpt_pkg::R_KV_DELIM:     kv_delim_q     <= cfg_data;
				kvpt_pkg::R_ESCAPE_BYTE:  escape_byte_q  <= cfg_data;
				kvpt_pkg::R_QUOTE_ENABLE: quote_enable_q <= cfg_data[0];
				kvpt_pkg::R_QUOTE_BYTE:   quote_byte_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode the held byte against the parser state.
	always_comb begin
		logic       err;
		logic [7:0] err_code;
		logic       store;
		logic       restart;
		nx_phase = phase_q;
		nx_len   = key_len_q;
		nx_esc   = esc_q;
		nx_quote = quote_q;
		wr_en    = 1'b0;
		burst    = 1'b0;
		t0_v     = 1'b0;
		t0_kind  = kvpt_pkg::K_END;
		t0_pay   = 8'd0;
		t1_v     = 1'b0;
		err      = 1'b0;
		err_code = kvpt_pkg::E_EMPTY_KEY;
		store    = 1'b0;
		restart  = 1'b0;
		unique case (phase_q)
			kvpt_pkg::PH_KEY: begin
				if (esc_q) begin
					nx_esc = 1'b0;
					store  = 1'b1;
				end else if (quote_enable_q && byte_q == quote_byte_q) begin
					if (quote_q) begin
						nx_quote = 1'b0;
						if (key_len_q == '0) err = 1'b1;
						else nx_phase = kvpt_pkg::PH_EXPECT_KV;
					end else begin
						nx_quote = 1'b1;
					end
				end else if (byte_q == kvpt_pkg::SPACE_BYTE && !quote_q) begin
					nx_len = '0;
				end else if (byte_q == escape_byte_q) begin
					nx_esc = 1'b1;
				end else if (byte_q == kv_delim_q) begin
					if (key_len_q == '0) begin
						err = 1'b1;
					end else if (eot_q) begin
						err      = 1'b1;
						err_code = kvpt_pkg::E_NO_DELIM;
					end else begin
						nx_phase = kvpt_pkg::PH_AFTER_KV;
					end
				end else begin
					store = 1'b1;
				end
				if (store) begin
					if (key_len_q >= LW'(MAX_KEY_LEN)) begin
						err      = 1'b1;
						err_code = kvpt_pkg::E_KEY_LONG;
					end else begin
						wr_en  = 1'b1;
						nx_len = key_len_q + LW'(1);
					end
				end
				if (!err && eot_q && nx_phase != kvpt_pkg::PH_AFTER_KV) begin
					err      = 1'b1;
					err_code = (nx_len == '0) ? kvpt_pkg::E_EMPTY_KEY : kvpt_pkg::E_NO_DELIM;
				end
			end
			kvpt_pkg::PH_EXPECT_KV: begin
				if (byte_q != kv_delim_q || eot_q) begin
					err      = 1'b1;
					err_code = kvpt_pkg::E_NO_DELIM;
				end else begin
					nx_phase = kvpt_pkg::PH_AFTER_KV;
				end
			end
			kvpt_pkg::PH_AFTER_KV, kvpt_pkg::PH_TRIM, kvpt_pkg::PH_VALUE: begin
				burst = (phase_q == kvpt_pkg::PH_AFTER_KV);
				if (byte_q == item_delim_q) begin
					t0_v    = 1'b1;
					restart = 1'b1;
				end else if (phase_q != kvpt_pkg::PH_VALUE
						&& byte_q == kvpt_pkg::SPACE_BYTE) begin
					// drop leading space
					nx_phase = kvpt_pkg::PH_TRIM;
				end else begin
					t0_v     = 1'b1;
					t0_kind  = kvpt_pkg::K_VALUE;
					t0_pay   = byte_q;
					nx_phase = kvpt_pkg::PH_VALUE;
				end
				if (eot_q) begin
					t1_v    = !restart;
					restart = 1'b1;
				end
			end
			kvpt_pkg::PH_ERROR: begin
				restart = eot_q;
			end
			default: ;
		endcase
		if (err) begin
			t0_v     = 1'b1;
			t0_kind  = kvpt_pkg::K_ERR;
			t0_pay   = err_code;
			nx_phase = kvpt_pkg::PH_ERROR;
			restart  = eot_q;
		end
		if (restart) begin
			nx_phase = kvpt_pkg::PH_KEY;
			nx_len   = '0;
			nx_esc   = 1'b0;
			nx_quote = 1'b0;
		end
	end

	// Advance the read address only when a key byte leaves.
	always_comb begin
		cnt_d = cnt_q;
		if (decode) begin
			cnt_d = '0;
		end else if (seq_q == kvpt_pkg::SQ_KEY && out_free && !key_last) begin
			cnt_d = cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (decode && wr_en) begin
			key_mem[key_len_q[AW-1:0]] <= byte_q;
		end
		rd_data_q <= key_mem[cnt_d];
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_q <= s_tdata;
			eot_q  <= s_tlast;
		end
		if (decode) begin
			t0_kind_q   <= t0_kind;
			t0_pay_q    <= t0_pay;
			burst_len_q <= key_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= kvpt_pkg::PH_KEY;
			key_len_q  <= '0;
			esc_q      <= 1'b0;
			quote_q    <= 1'b0;
			have_q     <= 1'b0;
			seq_q      <= kvpt_pkg::SQ_IDLE;
			cnt_q      <= '0;
			t0v_q      <= 1'b0;
			t1v_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			// a busy sequencer reloads the output register whenever it drains
			if (m_tready && seq_q == kvpt_pkg::SQ_IDLE) m_tvalid_q <= 1'b0;
			if (s_tvalid && s_tready) have_q <= 1'b1;
			unique case (seq_q)
				kvpt_pkg::SQ_IDLE: begin
					if (decode) begin
						phase_q   <= nx_phase;
						key_len_q <= nx_len;
						esc_q     <= nx_esc;
						quote_q   <= nx_quote;
						t0v_q     <= t0_v;
						t1v_q     <= t1_v;
						if (burst) seq_q <= kvpt_pkg::SQ_KEY;
						else if (t0_v || t1_v) seq_q <= kvpt_pkg::SQ_TAIL;
						else have_q <= 1'b0;
					end
				end
				kvpt_pkg::SQ_KEY: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= rd_data_q;
						m_tuser_q  <= kvpt_pkg::K_KEY;
						m_tlast_q  <= key_last && !t0v_q && !t1v_q;
						if (key_last) begin
							if (t0v_q || t1v_q) begin
								seq_q <= kvpt_pkg::SQ_TAIL;
							end else begin
								seq_q  <= kvpt_pkg::SQ_IDLE;
								have_q <= 1'b0;
							end
						end
					end
				end
				kvpt_pkg::SQ_TAIL: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (t0v_q) begin
							m_tdata_q <= t0_pay_q;
							m_tuser_q <= t0_kind_q;
							m_tlast_q <= !t1v_q;
							t0v_q     <= 1'b0;
						end else begin
							m_tdata_q <= 8'd0;
							m_tuser_q <= kvpt_pkg::K_END;
							m_tlast_q <= 1'b1;
							t1v_q     <= 1'b0;
						end
						if (!(t0v_q && t1v_q)) begin
							seq_q  <= kvpt_pkg::SQ_IDLE;
							have_q <= 1'b0;
						end
					end
				end
				default: seq_q <= kvpt_pkg::SQ_IDLE;
			endcase
		end
	end

	a_busy_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != kvpt_pkg::SQ_IDLE |-> have_q)
		else $error("sequencer busy without a held byte");

	a_key_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_len_q <= LW'(MAX_KEY_LEN))
		else $error("key length beyond the key memory");

	a_after_kv_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == kvpt_pkg::PH_AFTER_KV |-> key_len_q != '0)
		else $error("delimiter accepted with an empty key");

	a_err_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == kvpt_pkg::K_ERR |-> m_tlast)
		else $error("error result not last of its run");

endmodule
